@@ src/keyboard_receiver_autodetect_macros.svh @@
// Assertion macros for the keyboard receiver checker
`ifndef KEYBOARD_RECEIVER_AUTODETECT_MACROS_SVH
`define KEYBOARD_RECEIVER_AUTODETECT_MACROS_SVH

// same-cycle implication, disabled in reset
`define KBDRX_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define KBDRX_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/kbdrx_pkg.sv @@
// Shared types and codes for the keyboard receiver
package kbdrx_pkg;

    localparam logic [1:0] CMD_EDGE  = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;
    localparam logic [1:0] CMD_TICK  = 2'd3;

    localparam logic [1:0] PROTO_NONE     = 2'd0;
    localparam logic [1:0] PROTO_XT_CLONE = 2'd1;
    localparam logic [1:0] PROTO_XT_IBM   = 2'd2;
    localparam logic [1:0] PROTO_AT       = 2'd3;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_TIMEOUT   = 3'd1;
    localparam logic [2:0] ERR_ILLEGAL   = 3'd2;
    localparam logic [2:0] ERR_FF        = 3'd3;
    localparam logic [2:0] ERR_OVERWRITE = 3'd4;

    localparam logic [15:0] FRAME_EMPTY = 16'h8000;
    localparam logic [15:0] BUF_EMPTY   = 16'hFFFF;
    localparam logic [15:0] BUF_ILLEGAL = 16'hFF00;
    localparam logic [7:0]  SLOT_EMPTY  = 8'hFF;
    localparam logic [7:0]  WINDOW_RST  = 8'd100;

    typedef struct packed {
        logic [1:0] cmd;
        logic       data_bit;
        logic [7:0] ms_time;
    } t_item;

    typedef struct packed {
        logic       read_valid;
        logic [7:0] read_byte;
        logic [1:0] protocol;
        logic [2:0] error_code;
        logic [1:0] buffered_count;
    } t_result;

endpackage

@@ src/kbdrx_in_reg.sv @@
// Input register stage: holds one beat until the core can take it
module kbdrx_in_reg import kbdrx_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_item i_item,
    input  logic  i_hold,
    output logic  o_stall,
    output logic  o_valid,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;
    logic  load;

    assign load    = !(r_valid && i_hold);
    assign o_stall = !load;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

@@ src/kbdrx_core.sv @@
// Receiver state and per-beat update: framing, protocol detect, byte buffer
module kbdrx_core import kbdrx_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data,
    input  logic       i_fire,
    input  t_item      i_item,
    output t_result    o_result
);

    // low byte of the frame register after a shift
    localparam logic [7:0] PAT_BITS0    = 8'h00;
    localparam logic [7:0] PAT_BITS1    = 8'h80;
    localparam logic [7:0] PAT_BITS2    = 8'h40;
    localparam logic [7:0] PAT_BITS3    = 8'h20;
    localparam logic [7:0] PAT_XT_CLONE = 8'hC0;
    localparam logic [7:0] PAT_XT_AMBIG = 8'hA0;
    localparam logic [7:0] PAT_AT_0     = 8'h10;
    localparam logic [7:0] PAT_AT_1     = 8'h90;
    localparam logic [7:0] PAT_AT_2     = 8'h50;
    localparam logic [7:0] PAT_AT_3     = 8'hD0;

    logic [7:0]  r_window;
    logic [15:0] r_fs,    n_fs;
    logic [15:0] r_buf,   n_buf;
    logic [7:0]  r_start, n_start;
    logic [1:0]  r_proto, n_proto;
    logic [2:0]  r_err,   n_err;
    logic        r_pend,  n_pend;
    logic [7:0]  r_cnt,   n_cnt;

    logic        rd_valid;
    logic [7:0]  rd_byte;
    logic        fin;
    logic        fin_at;
    logic [1:0]  fin_proto;
    logic [7:0]  fin_byte;

    always_comb begin
        n_fs      = r_fs;
        n_buf     = r_buf;
        n_start   = r_start;
        n_proto   = r_proto;
        n_err     = r_err;
        n_pend    = r_pend;
        n_cnt     = r_cnt;
        rd_valid  = 1'b0;
        rd_byte   = 8'd0;
        fin       = 1'b0;
        fin_at    = 1'b0;
        fin_proto = PROTO_NONE;
        fin_byte  = 8'd0;

        case (i_item.cmd)
            CMD_EDGE: begin
                n_pend = 1'b0;
                n_cnt  = 8'd0;
                if (r_fs == FRAME_EMPTY) begin
                    n_start = i_item.ms_time;
                end else if (r_start != i_item.ms_time &&
                             (r_start + 8'd1) != i_item.ms_time) begin
                    // edges too far apart: restart the frame here
                    n_err   = ERR_TIMEOUT;
                    n_start = i_item.ms_time;
                    n_fs    = FRAME_EMPTY;
                end
                n_fs = {i_item.data_bit, n_fs[15:1]};
                case (n_fs[7:0])
                    PAT_BITS0, PAT_BITS1, PAT_BITS2, PAT_BITS3: begin
                    end
                    PAT_XT_CLONE: begin
                        fin       = 1'b1;
                        fin_proto = PROTO_XT_CLONE;
                    end
                    PAT_XT_AMBIG: begin
                        if (r_window == 8'd0) begin
                            fin       = 1'b1;
                            fin_proto = PROTO_XT_IBM;
                        end else begin
                            n_pend = 1'b1;
                        end
                    end
                    PAT_AT_0, PAT_AT_1, PAT_AT_2, PAT_AT_3: begin
                        fin       = 1'b1;
                        fin_at    = 1'b1;
                        fin_proto = PROTO_AT;
                    end
                    default: begin
                        n_err = ERR_ILLEGAL;
                        n_fs  = FRAME_EMPTY;
                        n_buf = BUF_ILLEGAL;
                    end
                endcase
            end
            CMD_READ: begin
                if (r_buf[15:8] != SLOT_EMPTY) begin
                    rd_byte     = r_buf[15:8];
                    rd_valid    = 1'b1;
                    n_buf[15:8] = SLOT_EMPTY;
                end else if (r_buf != BUF_EMPTY) begin
                    rd_byte  = r_buf[7:0];
                    rd_valid = 1'b1;
                    n_buf    = BUF_EMPTY;
                end
            end
            CMD_CLEAR: begin
                n_fs   = FRAME_EMPTY;
                n_buf  = BUF_EMPTY;
                n_pend = 1'b0;
                n_cnt  = 8'd0;
            end
            CMD_TICK: begin
                if (r_pend) begin
                    n_cnt = (r_cnt != 8'hFF) ? r_cnt + 8'd1 : r_cnt;
                    if (n_cnt >= r_window) begin
                        // no stop bit edge in the window: XT IBM frame
                        n_pend    = 1'b0;
                        n_cnt     = 8'd0;
                        fin       = 1'b1;
                        fin_proto = PROTO_XT_IBM;
                    end
                end
            end
            default: begin
            end
        endcase

        if (fin) begin
            fin_byte = fin_at ? n_fs[13:6] : n_fs[15:8];
            n_proto  = fin_proto;
            if (fin_byte == SLOT_EMPTY) begin
                n_err = ERR_FF;
            end
            if (n_buf[15:8] != SLOT_EMPTY) begin
                n_err = ERR_OVERWRITE;
            end
            n_buf = {n_buf[7:0], fin_byte};
            n_fs  = FRAME_EMPTY;
        end
    end

    assign o_result.read_valid     = rd_valid;
    assign o_result.read_byte      = rd_byte;
    assign o_result.protocol       = n_proto;
    assign o_result.error_code     = n_err;
    assign o_result.buffered_count = {1'b0, (n_buf[15:8] != SLOT_EMPTY)}
                                   + {1'b0, (n_buf[7:0] != SLOT_EMPTY)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WINDOW_RST;
            r_fs     <= FRAME_EMPTY;
            r_buf    <= BUF_EMPTY;
            r_start  <= 8'd0;
            r_proto  <= PROTO_NONE;
            r_err    <= ERR_NONE;
            r_pend   <= 1'b0;
            r_cnt    <= 8'd0;
        end else begin
            if (i_cfg_wr_en) begin
                r_window <= i_cfg_wr_data;
            end
            if (i_fire) begin
                r_fs    <= n_fs;
                r_buf   <= n_buf;
                r_start <= n_start;
                r_proto <= n_proto;
                r_err   <= n_err;
                r_pend  <= n_pend;
                r_cnt   <= n_cnt;
            end
        end
    end

endmodule

@@ src/kbdrx_out_reg.sv @@
// Result register: holds a beat while the downstream side stalls
module kbdrx_out_reg import kbdrx_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_result i_result,
    input  logic    i_stall,
    output logic    o_hold,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_hold   = r_valid && i_stall;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_hold) begin
            r_valid <= i_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_result <= i_result;
        end
    end

endmodule

@@ src/keyboard_receiver_autodetect.sv @@
// Top level of the auto-detecting keyboard frame receiver
//
//  channel  | handshake          | payload
//  ---------+--------------------+----------------------------------------------
//  in       | i_valid / o_stall  | i_cmd, i_data_bit, i_ms_time
//  out      | o_valid / i_stall  | o_read_valid, o_read_byte, o_protocol,
//           |                    | o_error_code, o_buffered_count
//  cfg      | i_cfg_wr_en        | i_cfg_wr_data (stop bit window, us ticks)
//
// One beat per cycle while the output is not stalled; each result passes the input and result registers.
// The input register feeds a combinational state update into the result register.
// Reset is synchronous: empty frame, empty buffer, window of 100 ticks.
// An output stall holds the result register and, in the same cycle, the input register, which then raises o_stall.
module keyboard_receiver_autodetect import kbdrx_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_cmd,
    input  logic       i_data_bit,
    input  logic [7:0] i_ms_time,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_read_valid,
    output logic [7:0] o_read_byte,
    output logic [1:0] o_protocol,
    output logic [2:0] o_error_code,
    output logic [1:0] o_buffered_count,
    input  logic       i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data
);

    t_item   in_item;
    t_item   core_item;
    logic    core_valid;
    logic    hold;
    logic    fire;
    t_result core_result;
    t_result out_result;

    assign in_item.cmd      = i_cmd;
    assign in_item.data_bit = i_data_bit;
    assign in_item.ms_time  = i_ms_time;
    assign fire             = core_valid && !hold;

    kbdrx_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_item  (in_item),
        .i_hold  (hold),
        .o_stall (o_stall),
        .o_valid (core_valid),
        .o_item  (core_item)
    );

    kbdrx_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_fire        (fire),
        .i_item        (core_item),
        .o_result      (core_result)
    );

    kbdrx_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_result (core_result),
        .i_stall  (i_stall),
        .o_hold   (hold),
        .o_valid  (o_valid),
        .o_result (out_result)
    );

    assign o_read_valid     = out_result.read_valid;
    assign o_read_byte      = out_result.read_byte;
    assign o_protocol       = out_result.protocol;
    assign o_error_code     = out_result.error_code;
    assign o_buffered_count = out_result.buffered_count;

endmodule

@@ src/kbdrx_checker.sv @@
// Port-level checker for the keyboard receiver, bound to the top level
`include "keyboard_receiver_autodetect_macros.svh"

module kbdrx_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic       o_read_valid,
    input logic [7:0] o_read_byte,
    input logic [2:0] o_error_code,
    input logic [1:0] o_buffered_count
);

    // a read never returns the empty-slot marker
    `KBDRX_ASSERT_NOW(a_read_not_ff, i_clk, i_rst_n, o_valid && o_read_valid, o_read_byte != 8'hFF, "read returned empty-slot marker")

    // no read result means a zero byte
    `KBDRX_ASSERT_NOW(a_noread_zero, i_clk, i_rst_n, o_valid && !o_read_valid, o_read_byte == 8'd0, "nonzero byte without read")

    // two slots at most, and only defined error codes
    `KBDRX_ASSERT_NOW(a_status_range, i_clk, i_rst_n, o_valid, (o_buffered_count != 2'd3) && (o_error_code <= 3'd4), "status out of range")

    // the input side stalls only when the result register is full
    `KBDRX_ASSERT_NOW(a_stall_needs_full, i_clk, i_rst_n, o_stall, o_valid && i_stall, "input stalled with output free")

    `KBDRX_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_read_byte) && $stable(o_error_code), "stalled result changed")

endmodule

bind keyboard_receiver_autodetect kbdrx_checker u_kbdrx_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_stall          (o_stall),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_read_valid     (o_read_valid),
    .o_read_byte      (o_read_byte),
    .o_error_code     (o_error_code),
    .o_buffered_count (o_buffered_count)
);

@@ tb/sv/keyboard_receiver_autodetect_test.sv @@
// Self-checking testbench for the auto-detecting keyboard frame receiver
`timescale 1ns / 100ps

module keyboard_receiver_autodetect_test;
    import kbdrx_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int MAX_PRINTED = 20;
    localparam int IDLE_PCT    = 32;

    // Expected-readout store with its own copy of the receiver state
    class scan_code_board;
        logic [7:0]  window;
        logic [15:0] shift;
        logic [15:0] rx_buf;
        logic [7:0]  start_ms;
        logic [1:0]  proto;
        logic [2:0]  err;
        logic        waiting;
        logic [7:0]  wait_ticks;
        t_result     expected_readouts[$];
        int          errors;
        int          results_seen;

        function new();
            window       = WINDOW_RST;
            shift        = FRAME_EMPTY;
            rx_buf       = BUF_EMPTY;
            start_ms     = '0;
            proto        = PROTO_NONE;
            err          = ERR_NONE;
            waiting      = 1'b0;
            wait_ticks   = '0;
            errors       = 0;
            results_seen = 0;
        endfunction

        function void complete_byte(int unsigned pos, logic [1:0] variant);
            logic [7:0] b;
            b = 8'(shift >> pos);
            proto = variant;
            if (b == SLOT_EMPTY)
                err = ERR_FF;
            if (rx_buf[15:8] != SLOT_EMPTY)
                err = ERR_OVERWRITE;
            rx_buf = {rx_buf[7:0], b};
            shift  = FRAME_EMPTY;
        endfunction

        function void clock_edge(logic bit_in, logic [7:0] t);
            logic [7:0] next_ms;
            next_ms = start_ms + 8'd1;
            if (waiting) begin
                waiting    = 1'b0;
                wait_ticks = '0;
            end
            if (shift == FRAME_EMPTY) begin
                start_ms = t;
            end else if (start_ms != t && next_ms != t) begin
                err      = ERR_TIMEOUT;
                start_ms = t;
                shift    = FRAME_EMPTY;
            end
            shift = {bit_in, shift[15:1]};
            case (shift[7:0])
                8'h00, 8'h80, 8'h40, 8'h20: ;
                8'hC0: complete_byte(8, PROTO_XT_CLONE);
                // XT IBM or AT so far: wait for a stop bit edge unless the window is zero
                8'hA0: begin
                    if (window == 0) begin
                        complete_byte(8, PROTO_XT_IBM);
                    end else begin
                        waiting    = 1'b1;
                        wait_ticks = '0;
                    end
                end
                8'h10, 8'h90, 8'h50, 8'hD0: complete_byte(6, PROTO_AT);
                default: begin
                    err    = ERR_ILLEGAL;
                    shift  = FRAME_EMPTY;
                    rx_buf = BUF_ILLEGAL;
                end
            endcase
        endfunction

        function void us_tick();
            if (!waiting)
                return;
            if (wait_ticks != 8'hFF)
                wait_ticks++;
            if (wait_ticks >= window) begin
                waiting    = 1'b0;
                wait_ticks = '0;
                complete_byte(8, PROTO_XT_IBM);
            end
        endfunction

        function void note_beat(t_item it);
            t_result r;
            r = '0;
            case (it.cmd)
                CMD_EDGE: clock_edge(it.data_bit, it.ms_time);
                CMD_READ: begin
                    if (rx_buf[15:8] != SLOT_EMPTY) begin
                        r.read_valid  = 1'b1;
                        r.read_byte   = rx_buf[15:8];
                        rx_buf[15:8]  = SLOT_EMPTY;
                    end else if (rx_buf != BUF_EMPTY) begin
                        r.read_valid  = 1'b1;
                        r.read_byte   = rx_buf[7:0];
                        rx_buf        = BUF_EMPTY;
                    end
                end
                CMD_CLEAR: begin
                    shift      = FRAME_EMPTY;
                    rx_buf     = BUF_EMPTY;
                    waiting    = 1'b0;
                    wait_ticks = '0;
                end
                default: us_tick();
            endcase
            r.protocol       = proto;
            r.error_code     = err;
            r.buffered_count = 2'(rx_buf[15:8] != SLOT_EMPTY) + 2'(rx_buf[7:0] != SLOT_EMPTY);
            expected_readouts.push_back(r);
        endfunction

        task report(string what);
            errors++;
            if (errors <= MAX_PRINTED)
                $display("ERROR @%0t: %s", $realtime, what);
        endtask

        task check_field(string name, logic [7:0] got, logic [7:0] want);
            if (got !== want)
                report($sformatf("%s got %0h expected %0h (result %0d)",
                                 name, got, want, results_seen));
        endtask

        task check_readout(t_result got);
            t_result want;
            results_seen++;
            if (expected_readouts.size() == 0) begin
                report($sformatf("result %h with nothing expected", got));
                return;
            end
            want = expected_readouts.pop_front();
            check_field("read_valid", 8'(got.read_valid), 8'(want.read_valid));
            check_field("read_byte", got.read_byte, want.read_byte);
            check_field("protocol", 8'(got.protocol), 8'(want.protocol));
            check_field("error_code", 8'(got.error_code), 8'(want.error_code));
            check_field("buffered_count", 8'(got.buffered_count), 8'(want.buffered_count));
        endtask
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [1:0] i_cmd;
    logic       i_data_bit;
    logic [7:0] i_ms_time;
    logic       o_valid;
    logic       i_stall;
    logic       o_read_valid;
    logic [7:0] o_read_byte;
    logic [1:0] o_protocol;
    logic [2:0] o_error_code;
    logic [1:0] o_buffered_count;
    logic       i_cfg_wr_en;
    logic [7:0] i_cfg_wr_data;

    scan_code_board sb = new();
    int         items_sent = 0;
    int         quiet_cycles = 0;
    bit         calm = 1'b0;
    logic [7:0] now_ms = 8'd0;
    logic [7:0] window_now = WINDOW_RST;

    keyboard_receiver_autodetect dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_cmd            (i_cmd),
        .i_data_bit       (i_data_bit),
        .i_ms_time        (i_ms_time),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_read_valid     (o_read_valid),
        .o_read_byte      (o_read_byte),
        .o_protocol       (o_protocol),
        .o_error_code     (o_error_code),
        .o_buffered_count (o_buffered_count),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall)
                sb.note_beat(t_item'({i_cmd, i_data_bit, i_ms_time}));
            if (o_valid && !i_stall)
                sb.check_readout(t_result'({o_read_valid, o_read_byte, o_protocol,
                                            o_error_code, o_buffered_count}));
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", QUIET_LIMIT);
            $display("keyboard_receiver_autodetect_test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_item(input logic [1:0] cmd, input logic bit_in, input logic [7:0] ms);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_cmd      <= cmd;
        i_data_bit <= bit_in;
        i_ms_time  <= ms;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        items_sent++;
    endtask

    task automatic send_other(input logic [1:0] cmd);
        send_item(cmd, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    endtask

    // first edge sets the start time; later ones stay within one ms of it or, rarely, force a timeout
    task automatic send_edge(input logic b, input bit first);
        logic [7:0] ms;
        if (!first && $urandom_range(0, 99) < 4) begin
            now_ms = now_ms + 8'($urandom_range(2, 255));
            ms     = now_ms;
        end else if (first) begin
            ms = now_ms;
        end else begin
            ms = now_ms + 8'($urandom_range(0, 1));
        end
        send_item(CMD_EDGE, b, ms);
    endtask

    task automatic send_frame(input logic [10:0] bits, input int n, input bit exact);
        int len;
        len = n;
        if (!exact && $urandom_range(0, 99) < 8)
            len = $urandom_range(1, n - 1);
        if ($urandom_range(0, 99) < 70)
            now_ms = now_ms + 8'($urandom_range(0, 2));
        else
            now_ms = now_ms + 8'($urandom_range(0, 255));
        for (int i = 0; i < len; i++)
            send_edge(bits[i], i == 0);
    endtask

    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 8'hFF;
        if (r < 20)
            return 8'h00;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_clone(input logic [7:0] d, input bit exact);
        send_frame({2'b00, d, 1'b1}, 9, exact);
    endtask

    task automatic send_at(input logic [7:0] d, input bit exact);
        send_frame({1'b1, ~^d, d, 1'b0}, 11, exact);
    endtask

    // two start bits; with a nonzero window, either the window runs out or a late stop edge turns it AT
    task automatic send_xt_ibm(input logic [7:0] d);
        int n;
        send_frame({1'b0, d, 2'b10}, 10, 1'b0);
        if (window_now == 0)
            return;
        if ($urandom_range(0, 1)) begin
            n = window_now + $urandom_range(0, 1);
            repeat (n) send_other(CMD_TICK);
        end else begin
            n = $urandom_range(0, window_now - 1);
            repeat (n) send_other(CMD_TICK);
            send_edge(1'b1, 1'b0);
        end
    endtask

    task automatic random_sequence();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25)
            send_clone(pick_byte(), 1'b0);
        else if (r < 45)
            send_at(pick_byte(), 1'b0);
        else if (r < 58)
            send_xt_ibm(pick_byte());
        else if (r < 74)
            repeat ($urandom_range(1, 3)) send_other(CMD_READ);
        else if (r < 79)
            send_other(CMD_CLEAR);
        else if (r < 85)
            repeat ($urandom_range(1, 3)) send_other(CMD_TICK);
        else
            repeat ($urandom_range(1, 4)) send_other(2'($urandom_range(0, 3)));
    endtask

    task automatic run_random(input int target);
        while (items_sent < target)
            random_sequence();
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.results_seen < items_sent)
            @(posedge i_clk);
    endtask

    task automatic write_window(input logic [7:0] v);
        drain();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        window_now     = v;
        sb.window      = v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_stall       <= 1'b0;
        i_cmd         <= CMD_EDGE;
        i_data_bit    <= 1'b0;
        i_ms_time     <= 8'd0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= 8'd0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty read, idle tick and clear, 0xFF byte, two AT bytes read back
        send_other(CMD_READ);
        send_other(CMD_TICK);
        send_other(CMD_CLEAR);
        send_clone(8'hFF, 1'b1);
        send_at(8'h00, 1'b1);
        send_at(8'h81, 1'b1);
        send_other(CMD_READ);
        send_other(CMD_READ);
        run_random(items_sent + 80);

        calm = 1'b1;
        write_window(8'd1);
        run_random(items_sent + 100);
        calm = 1'b0;

        write_window(8'd0);
        run_random(items_sent + 90);

        write_window(8'd255);
        run_random(items_sent + 100);

        write_window(8'($urandom_range(2, 20)));
        run_random(items_sent + 130);

        drain();
        repeat (8) @(posedge i_clk);
        if (sb.expected_readouts.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.expected_readouts.size()));
        if (sb.errors == 0)
            $display("keyboard_receiver_autodetect_test passed");
        else
            $display("keyboard_receiver_autodetect_test failed");
        $finish;
    end

endmodule
